### rtl/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg: shared constants for the half float converter
// Mode codes and IEEE 754 encoding constants.
// ----------------------------------------------------------------------------
package hfc_pkg;

  typedef enum logic {
    MODE_S2H = 1'b0,
    MODE_H2S = 1'b1
  } mode_t;

  localparam logic [15:0] H_INF    = 16'h7C00;
  localparam logic [31:0] S_INF    = 32'h7F80_0000;
  localparam logic [31:0] S_QNAN   = 32'h7FC0_0000;
  localparam logic [22:0] S_ROUND  = 23'h00_1000;

endpackage

### rtl/half_float_converter.sv
// ----------------------------------------------------------------------------
// half_float_converter: binary32 <-> binary16 bit pattern converter
// Mode 0 narrows binary32 to binary16, mode 1 widens binary16 to binary32.
// ----------------------------------------------------------------------------
// One result per transaction, one transaction per cycle while out_stall does
// not hold the pipeline. Each item is registered at the input, converted by a
// single pass of shift, round and leading-one logic, and held in a result
// register until it is taken.
// Narrowing rounds normal results half away
// from zero, truncates half subnormals, flushes tiny values and float
// subnormals to signed zero, and maps infinity and NaN to signed infinity.
// Widening is exact; NaN becomes a signed quiet NaN.
module half_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] converted_bits
);

  logic        in_reg_valid;
  logic        in_reg_mode;
  logic [31:0] in_reg_bits;
  logic        res_advance;
  logic        in_advance;
  logic [31:0] result_next;

  // Pipeline moves when the result slot is free or being taken
  assign res_advance = !out_valid || !out_stall;
  assign in_advance  = !in_reg_valid || res_advance;
  assign in_stall    = !in_advance;

  // Capture input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_advance) begin
      in_reg_valid <= in_valid;
    end
    if (in_advance && in_valid) begin
      in_reg_mode <= mode;
      in_reg_bits <= operand_bits;
    end
  end

  // Narrowing path
  logic        s_sign;
  logic [7:0]  s_exp;
  logic [22:0] s_frac;
  logic [15:0] h_res;
  logic [23:0] s_sub;
  logic [4:0]  s_sh;
  logic [23:0] s_rnd;
  logic [4:0]  h_e;

  always_comb begin
    s_sign = in_reg_bits[31];
    s_exp  = in_reg_bits[30:23];
    s_frac = in_reg_bits[22:0];
    h_e    = 5'(s_exp - 8'd112);
    s_sh   = 5'(8'd113 - s_exp);
    s_sub  = {1'b1, s_frac} >> s_sh;
    s_rnd  = {1'b0, s_frac} + {1'b0, hfc_pkg::S_ROUND} + 24'(s_frac[12]);
    if (in_reg_bits[30:0] == 31'd0) begin
      h_res = {s_sign, 15'd0};
    end else if (s_exp >= 8'd143) begin
      h_res = {s_sign, 15'd0} | hfc_pkg::H_INF;
    end else if (s_exp <= 8'd112) begin
      if (s_exp < 8'd102) begin
        h_res = {s_sign, 15'd0};
      end else begin
        h_res = {s_sign, 5'd0, s_sub[22:13]};
      end
    end else if (s_rnd[23]) begin
      h_res = {s_sign, 5'(h_e + 5'd1), 10'd0};
    end else begin
      h_res = {s_sign, h_e, s_rnd[22:13]};
    end
  end

  // Widening path
  logic        w_sign;
  logic [4:0]  w_exp;
  logic [9:0]  w_frac;
  logic [3:0]  w_p;
  logic [31:0] s_res;
  logic [22:0] w_norm;

  always_comb begin
    w_sign = in_reg_bits[15];
    w_exp  = in_reg_bits[14:10];
    w_frac = in_reg_bits[9:0];
    w_p    = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (w_frac[i]) w_p = 4'(i);
    end
    w_norm = 23'({w_frac, 13'd0} << (5'd10 - 5'(w_p)));
    if (w_exp == 5'd0) begin
      if (w_frac == 10'd0) begin
        s_res = {w_sign, 31'd0};
      end else begin
        s_res = {w_sign, 8'(8'd103 + 8'(w_p)), w_norm};
      end
    end else if (w_exp == 5'h1F) begin
      s_res = {w_sign, 31'd0} |
              ((w_frac == 10'd0) ? hfc_pkg::S_INF : hfc_pkg::S_QNAN);
    end else begin
      s_res = {w_sign, 8'(8'd112 + 8'(w_exp)), w_frac, 13'd0};
    end
  end

  assign result_next = (in_reg_mode == hfc_pkg::MODE_H2S) ? s_res : {16'd0, h_res};

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_advance) begin
      out_valid <= in_reg_valid;
    end
    if (res_advance && in_reg_valid) begin
      converted_bits <= result_next;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(converted_bits))
    else $error("result changed while stalled");
  a_s2h_upper: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && res_advance && in_reg_mode == hfc_pkg::MODE_S2H
      |=> converted_bits[31:16] == 16'd0)
    else $error("narrowed result has upper bits set");
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !res_advance |=> in_reg_valid)
    else $error("pending transaction lost");

endmodule

### sim/hfc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hfc_checker: conversion predictor and result scoreboard
// Watches both channels of the half float converter, computes the expected
// bit pattern for every accepted transaction and compares each result with
// the oldest pending prediction.
// ----------------------------------------------------------------------------
module hfc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        mode,
  input  logic [31:0] operand_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] converted_bits,
  output int          fail_count,
  output int          pending_count
);

  logic [31:0] expected_bits_q[$];

  // Narrow a binary32 pattern to binary16
  function automatic logic [31:0] narrow_to_half(logic [31:0] b);
    logic [15:0] s16;
    int          e;
    logic [22:0] frac;
    logic [23:0] sig;
    logic [23:0] m;
    s16  = {b[31], 15'd0};
    e    = int'(b[30:23]) - 127 + 15;
    frac = b[22:0];
    if (b[30:0] == 31'd0) return {16'd0, s16};
    if (e >= 31) return {16'd0, s16 | hfc_pkg::H_INF};
    if (e <= 0) begin
      if (e < -10) return {16'd0, s16};
      sig = {1'b1, frac} >> (1 - e);
      return {16'd0, s16 | {6'd0, sig[22:13]}};
    end
    m = ({1'b0, frac} + {1'b0, hfc_pkg::S_ROUND} + 24'(frac[12])) >> 13;
    if (m >= 24'd1024) return {16'd0, s16 | 16'((e + 1) << 10)};
    return {16'd0, s16 | 16'(e << 10) | {6'd0, m[9:0]}};
  endfunction

  // Widen a binary16 pattern to binary32
  function automatic logic [31:0] widen_to_single(logic [15:0] h);
    logic [31:0] sign;
    logic [4:0]  e;
    logic [9:0]  frac;
    int          p;
    sign = {h[15], 31'd0};
    e    = h[14:10];
    frac = h[9:0];
    if (e == 5'd0) begin
      if (frac == 10'd0) return sign;
      p = 9;
      while (!frac[p]) p--;
      return sign | (32'(p + 103) << 23) | ((32'(frac) << (23 - p)) & 32'h007F_FFFF);
    end
    if (e == 5'h1F) return sign | ((frac == 10'd0) ? hfc_pkg::S_INF : hfc_pkg::S_QNAN);
    return sign | (32'(e + 8'd112) << 23) | (32'(frac) << 13);
  endfunction

  assign pending_count = expected_bits_q.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    logic [31:0] want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (hfc_pkg::mode_t'(mode) == hfc_pkg::MODE_S2H)
          expected_bits_q.push_back(narrow_to_half(operand_bits));
        else expected_bits_q.push_back(widen_to_single(operand_bits[15:0]));
      end
      if (out_valid && !out_stall) begin
        if (expected_bits_q.size() == 0) begin
          $error("converted_bits: unexpected result, actual %h", converted_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_bits_q.pop_front();
          if (want !== converted_bits) begin
            $error("converted_bits: expected %h, actual %h", want, converted_bits);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: half float converter stimulus and verdict
// Drives directed corner patterns and random conversions with random idling
// on both channels, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic [31:0] operand_bits;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] converted_bits;
  int          fail_count;
  int          pending_count;
  bit          quiet_phase;
  bit          hold_off;

  half_float_converter DUT (.*);

  hfc_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stall, plus one long hold-off
  initial begin
    int cnt;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (cnt = 0; cnt < 60; cnt++) @(negedge clk);
        hold_off = 1'b0;
      end
      out_stall <= quiet_phase ? 1'b0 : ($urandom_range(99) < 16);
    end
  end

  // Offer one transaction and wait for it to be taken; valid stays high after
  // return so the next transaction can follow back to back
  task automatic send_conversion(logic m, logic [31:0] bits);
    while (!quiet_phase && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    operand_bits <= bits;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random binary32 pattern weighted toward interesting exponents
  function automatic logic [31:0] random_single();
    logic [7:0] ex;
    case ($urandom_range(5))
      0: ex = 8'($urandom_range(255));
      1: ex = 8'($urandom_range(101, 113));
      2: ex = 8'($urandom_range(140, 143));
      3: ex = $urandom_range(1) ? 8'hFF : 8'h00;
      default: ex = 8'($urandom_range(112, 142));
    endcase
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  initial begin
    logic [31:0] directed[$];
    logic [31:0] r;
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = 1'b0;
    operand_bits = 32'd0;
    quiet_phase = 1'b0;
    hold_off = 1'b0;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // Narrowing corners: zeros, inf, NaN, overflow, subnormal, underflow, carry
    directed = {32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                32'h7FC0_0001, 32'h477F_F000, 32'h477F_E000, 32'h3880_0000,
                32'h3380_0000, 32'h3300_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                32'h3F80_1000, 32'h3F80_0FFF};
    foreach (directed[k]) send_conversion(hfc_pkg::MODE_S2H, directed[k]);
    // Widening corners: ignored high bits, subnormals, inf, NaN
    directed = {32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_03FF,
                32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'h0000_FFFF,
                32'h0000_3C00, 32'hAAAA_7BFF};
    foreach (directed[k]) send_conversion(hfc_pkg::MODE_H2S, directed[k]);

    // Random, with a quiet stretch, a long hold-off and a drain pause
    for (i = 0; i < 450; i++) begin
      quiet_phase = (i >= 100 && i < 160);
      if (i == 200) hold_off = 1'b1;
      if (i == 320) begin
        in_valid <= 1'b0;
        wait (pending_count == 0);
        @(negedge clk);
      end
      r = $urandom_range(1) ? random_single() : $urandom;
      send_conversion(1'($urandom), r);
    end

    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (10) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
